// ===== sv/mptl_pkg.sv =====
`timescale 1ns / 1ps
// preset table lookup: shared types, field widths and constants
// no dependencies; used by mptl_if, mptl_scan, the top unit and the testbench
package mptl_pkg;

  localparam int BANK_W      = 8;
  localparam int PROG_W      = 7;
  localparam int ENTRY_W     = BANK_W + PROG_W;
  localparam int QBANK_W     = 7;
  localparam int CHAN_W      = 4;
  localparam int SLOT_W      = 8;
  localparam int FOUND_W     = 8;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CHAN_W-1:0]  DRUM_CHANNEL   = 4'd9;
  localparam logic [BANK_W-1:0]  DRUM_BANK      = 8'd128;
  localparam logic [QBANK_W-1:0] XG_DRUM_BANK_A = 7'd126;
  localparam logic [QBANK_W-1:0] XG_DRUM_BANK_B = 7'd127;
  localparam logic [MODE_W-1:0]  MODE_GM        = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_GS        = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_XG        = 2'd2;
  localparam logic [MODE_W-1:0]  MODE_RSVD      = 2'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIDI_MODE    = 1'b0,
    CFG_PRESET_COUNT = 1'b1
  } cfg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXACT    = 2'd0,
    KIND_FALLBACK = 2'd1,
    KIND_DEFAULT  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } scan_state_e;

  typedef struct packed {
    logic [BANK_W-1:0] target;
    logic [PROG_W-1:0] qprog;
    logic              drum;
  } query_t;

  typedef struct packed {
    logic [FOUND_W-1:0] found_index;
    kind_e              match_kind;
  } res_t;

endpackage

// ===== sv/mptl_if.sv =====
`timescale 1ns / 1ps
// preset table lookup: input and output channel interfaces
// depends on mptl_pkg for field widths
interface mptl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [mptl_pkg::SLOT_W-1:0]   entry_slot;
  logic [mptl_pkg::BANK_W-1:0]   entry_bank;
  logic [mptl_pkg::PROG_W-1:0]   entry_program;
  logic [mptl_pkg::QBANK_W-1:0]  query_bank;
  logic [mptl_pkg::PROG_W-1:0]   query_program;
  logic [mptl_pkg::CHAN_W-1:0]   channel;

  modport source (
    output valid, opcode, entry_slot, entry_bank, entry_program,
           query_bank, query_program, channel,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_slot, entry_bank, entry_program,
           query_bank, query_program, channel,
    output ready
  );
endinterface

interface mptl_out_if;
  logic                         valid;
  logic                         ready;
  logic [mptl_pkg::FOUND_W-1:0] found_index;
  logic [mptl_pkg::KIND_W-1:0]  match_kind;

  modport source (output valid, found_index, match_kind, input ready);
  modport sink (input valid, found_index, match_kind, output ready);
endinterface

// ===== sv/mptl_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module mptl_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mptl_scan.sv =====
`timescale 1ns / 1ps
// preset table lookup: scan sequencer with shared entry compare unit
// depends on mptl_pkg; drives the read port of mptl_ram
module mptl_scan #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  mptl_pkg::query_t                     query_i,
  input  logic [(($clog2(TABLE_DEPTH + 1) > 9) ? $clog2(TABLE_DEPTH + 1) : 9)-1:0] count_i,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr_o,
  input  logic [mptl_pkg::ENTRY_W-1:0]         rdata_i,
  output logic                                 idle_o,
  output logic                                 res_valid_o,
  input  logic                                 res_take_i,
  output mptl_pkg::res_t                       res_o
);

  localparam int CW    = ($clog2(TABLE_DEPTH + 1) > 9) ? $clog2(TABLE_DEPTH + 1) : 9;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  mptl_pkg::scan_state_e state_q, state_d;
  logic [CW-1:0]                  addr_q, count_q;
  logic                           chk_q;
  logic [mptl_pkg::FOUND_W-1:0]   chk_idx_q;
  mptl_pkg::query_t               query_q;
  logic                           fb_q;
  logic [mptl_pkg::FOUND_W-1:0]   fb_idx_q;
  mptl_pkg::res_t                 res_q;

  logic [mptl_pkg::BANK_W-1:0] ent_bank;
  logic [mptl_pkg::PROG_W-1:0] ent_prog;
  logic                        scanning, issue, exact, fb_match, hit, finish;

  assign ent_bank = rdata_i[mptl_pkg::ENTRY_W-1:mptl_pkg::PROG_W];
  assign ent_prog = rdata_i[mptl_pkg::PROG_W-1:0];

  // shared compare unit, one entry per cycle
  assign exact    = (ent_bank == query_q.target) && (ent_prog == query_q.qprog);
  assign fb_match = query_q.drum ? (ent_bank == mptl_pkg::DRUM_BANK)
                                 : ((ent_bank == '0) && (ent_prog == query_q.qprog));

  always_comb begin
    scanning    = (state_q == mptl_pkg::ST_SCAN);
    issue       = scanning && (addr_q != count_q);
    hit         = scanning && chk_q && exact;
    finish      = scanning && !chk_q && (addr_q == count_q);
    idle_o      = (state_q == mptl_pkg::ST_IDLE);
    res_valid_o = (state_q == mptl_pkg::ST_RESULT);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mptl_pkg::ST_IDLE: begin
        if (start_i) state_d = mptl_pkg::ST_SCAN;
      end
      mptl_pkg::ST_SCAN: begin
        if (hit || finish) state_d = mptl_pkg::ST_RESULT;
      end
      mptl_pkg::ST_RESULT: begin
        if (res_take_i) state_d = mptl_pkg::ST_IDLE;
      end
      default: state_d = mptl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mptl_pkg::ST_IDLE;
      chk_q   <= 1'b0;
      fb_q    <= 1'b0;
      addr_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (start_i && idle_o) begin
        addr_q  <= '0;
        count_q <= count_i;
        chk_q   <= 1'b0;
        fb_q    <= 1'b0;
      end else if (scanning) begin
        if (issue) addr_q <= addr_q + CW'(1);
        chk_q <= issue && !hit;
        if (chk_q && fb_match && !fb_q) fb_q <= 1'b1;
      end else begin
        chk_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && idle_o) begin
      query_q <= query_i;
    end
    if (scanning) begin
      chk_idx_q <= addr_q[mptl_pkg::FOUND_W-1:0];
      if (chk_q && fb_match && !fb_q) fb_idx_q <= chk_idx_q;
      if (hit) begin
        res_q.found_index <= chk_idx_q;
        res_q.match_kind  <= mptl_pkg::KIND_EXACT;
      end else if (finish) begin
        if (fb_q) begin
          res_q.found_index <= fb_idx_q;
          res_q.match_kind  <= mptl_pkg::KIND_FALLBACK;
        end else if (count_q != '0) begin
          res_q.found_index <= '0;
          res_q.match_kind  <= mptl_pkg::KIND_DEFAULT;
        end else begin
          res_q.found_index <= '0;
          res_q.match_kind  <= mptl_pkg::KIND_NONE;
        end
      end
    end
  end

  assign raddr_o = addr_q[IDX_W-1:0];
  assign res_o   = res_q;

  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> (addr_q <= count_q))
    else $error("scan address ran past the entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_o |-> (count_q <= CW'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  a_no_chk_outside_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mptl_pkg::ST_RESULT) |=> !chk_q)
    else $error("compare stage still busy after result");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i) && $past(idle_o)) |-> scanning)
    else $error("query start did not enter scan");

endmodule

// ===== sv/midi_preset_table_lookup_unit.sv =====
`timescale 1ns / 1ps
// A write transaction (opcode 0) stores bank and program at entry_slot. A query
// transaction (opcode 1) walks the table from entry 0 through the single ram read
// port, one entry per cycle, and stops at the first exact match; it scans at most
// preset_count entries (count clamped to TABLE_DEPTH), and the next transaction
// can be accepted once its result has moved into the output register. Input is
// not ready during a scan or while its result waits for a full output register.
// No clearing pass at reset.
// Depends on mptl_pkg, mptl_if, mptl_ram and mptl_scan.
module midi_preset_table_lookup_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mptl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mptl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  mptl_in_if.sink                             in_ch,
  mptl_out_if.source                          out_ch
);

  localparam int CW    = ($clog2(TABLE_DEPTH + 1) > 9) ? $clog2(TABLE_DEPTH + 1) : 9;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [mptl_pkg::MODE_W-1:0]  mode_q;
  logic [mptl_pkg::COUNT_W-1:0] pcount_q;
  logic [CW-1:0]                count_w, count_eff;

  logic                         accept, start, ram_we, scan_idle;
  logic                         res_valid, res_take;
  logic                         xg_drum;
  mptl_pkg::query_t             query;
  mptl_pkg::res_t               scan_res, out_q;
  logic                         out_valid_q;
  logic [IDX_W-1:0]             raddr;
  logic [mptl_pkg::ENTRY_W-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mptl_pkg::CFG_MIDI_MODE:    mode_q   <= cfg_wdata_i[mptl_pkg::MODE_W-1:0];
        mptl_pkg::CFG_PRESET_COUNT: pcount_q <= cfg_wdata_i[mptl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_w   = CW'(pcount_q);
  assign count_eff = (count_w > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : count_w;

  assign in_ch.ready = scan_idle;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept && (in_ch.opcode == mptl_pkg::OP_QUERY);
  assign ram_we      = accept && (in_ch.opcode == mptl_pkg::OP_WRITE) &&
                       (32'(in_ch.entry_slot) < 32'(TABLE_DEPTH));

  // drum requests search the drum kit bank
  assign xg_drum = (mode_q == mptl_pkg::MODE_XG) &&
                   ((in_ch.query_bank == mptl_pkg::XG_DRUM_BANK_A) ||
                    (in_ch.query_bank == mptl_pkg::XG_DRUM_BANK_B));

  always_comb begin
    query.qprog = in_ch.query_program;
    query.drum  = (in_ch.channel == mptl_pkg::DRUM_CHANNEL) || xg_drum;
    query.target = query.drum ? mptl_pkg::DRUM_BANK
                              : mptl_pkg::BANK_W'(in_ch.query_bank);
  end

  mptl_ram #(
    .WIDTH (mptl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(in_ch.entry_slot)),
    .wdata_i ({in_ch.entry_bank, in_ch.entry_program}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mptl_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .query_i     (query),
    .count_i     (count_eff),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .idle_o      (scan_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (scan_res)
  );

  // output register parts the scan from the sink
  assign res_take = res_valid && (!out_valid_q || out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= scan_res;
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.found_index = out_q.found_index;
  assign out_ch.match_kind  = out_q.match_kind;

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> scan_idle)
    else $error("table write during a scan");

  a_none_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (scan_res.match_kind == mptl_pkg::KIND_NONE)) |->
      (scan_res.found_index == '0))
    else $error("empty table result carries an index");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting result transaction changed");

endmodule

// ===== tb/tb_midi_preset_table_lookup_unit.sv =====
`timescale 1ns / 1ps
// testbench for midi_preset_table_lookup_unit: table writes and lookups under random
// idling and back-pressure, each result checked against an in-bench lookup predictor
// depends on mptl_pkg, mptl_if and the rtl of the unit
module tb_midi_preset_table_lookup_unit;

  localparam int TABLE_DEPTH = 256;
  localparam int ITEM_TARGET = 1400;
  localparam int CFG_SETTLE  = 8;
  localparam int END_SETTLE  = TABLE_DEPTH + 8;
  localparam int RX_HOLD     = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    mptl_pkg::op_e                op;
    logic [mptl_pkg::SLOT_W-1:0]  slot;
    logic [mptl_pkg::BANK_W-1:0]  bank;
    logic [mptl_pkg::PROG_W-1:0]  prog;
    logic [mptl_pkg::QBANK_W-1:0] qbank;
    logic [mptl_pkg::PROG_W-1:0]  qprog;
    logic [mptl_pkg::CHAN_W-1:0]  chan;
  } midi_req_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [mptl_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mptl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  mptl_in_if  in_ch();
  mptl_out_if out_ch();

  midi_preset_table_lookup_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  logic [mptl_pkg::ENTRY_W-1:0] table_shadow [TABLE_DEPTH];
  bit                           slot_loaded  [TABLE_DEPTH];
  logic [mptl_pkg::MODE_W-1:0]  mode_shadow  = '0;
  logic [mptl_pkg::COUNT_W-1:0] count_shadow = '0;
  mptl_pkg::res_t               expected_lookups [$];
  int                           mismatches   = 0;
  int                           items_sent   = 0;
  int                           send_gap_max = 7;
  int                           recv_gap_max = 7;
  bit                           rx_hold_req  = 1'b0;

  function automatic int active_entries();
    return (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_shadow);
  endfunction

  function automatic mptl_pkg::res_t predict_lookup(
      input logic [mptl_pkg::QBANK_W-1:0] qbank,
      input logic [mptl_pkg::PROG_W-1:0]  qprog,
      input logic [mptl_pkg::CHAN_W-1:0]  chan);
    int                           n;
    int                           i;
    logic [mptl_pkg::BANK_W-1:0]  target;
    logic [mptl_pkg::BANK_W-1:0]  bank;
    logic [mptl_pkg::PROG_W-1:0]  prog;
    logic                         drum;
    logic                         have_fb;
    logic [mptl_pkg::FOUND_W-1:0] fb;
    mptl_pkg::res_t               res;
    n = active_entries();
    target = mptl_pkg::BANK_W'(qbank);
    drum = (chan == mptl_pkg::DRUM_CHANNEL);
    if (drum) begin
      target = mptl_pkg::DRUM_BANK;
    end else if (mode_shadow == mptl_pkg::MODE_XG &&
                 (qbank == mptl_pkg::XG_DRUM_BANK_A ||
                  qbank == mptl_pkg::XG_DRUM_BANK_B)) begin
      target = mptl_pkg::DRUM_BANK;
      drum = 1'b1;
    end
    have_fb = 1'b0;
    fb = '0;
    for (i = 0; i < n; i++) begin
      {bank, prog} = table_shadow[i];
      if (bank == target && prog == qprog) begin
        res.found_index = mptl_pkg::FOUND_W'(i);
        res.match_kind = mptl_pkg::KIND_EXACT;
        return res;
      end
      if (!have_fb && (drum ? (bank == mptl_pkg::DRUM_BANK)
                            : (bank == '0 && prog == qprog))) begin
        have_fb = 1'b1;
        fb = mptl_pkg::FOUND_W'(i);
      end
    end
    if (have_fb) begin
      res.found_index = fb;
      res.match_kind = mptl_pkg::KIND_FALLBACK;
    end else if (n > 0) begin
      res.found_index = '0;
      res.match_kind = mptl_pkg::KIND_DEFAULT;
    end else begin
      res.found_index = '0;
      res.match_kind = mptl_pkg::KIND_NONE;
    end
    return res;
  endfunction

  function automatic logic [mptl_pkg::BANK_W-1:0] pick_bank();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return mptl_pkg::DRUM_BANK;
      4:       return mptl_pkg::BANK_W'(mptl_pkg::XG_DRUM_BANK_A);
      5:       return mptl_pkg::BANK_W'(mptl_pkg::XG_DRUM_BANK_B);
      6:       return mptl_pkg::BANK_W'(1);
      7:       return '1;
      default: return mptl_pkg::BANK_W'($urandom);
    endcase
  endfunction

  function automatic logic [mptl_pkg::PROG_W-1:0] pick_prog();
    if ($urandom_range(0, 3) == 0) return mptl_pkg::PROG_W'($urandom);
    return mptl_pkg::PROG_W'($urandom_range(0, 7));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_item(input midi_req_t req);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= req.op;
    in_ch.entry_slot    <= req.slot;
    in_ch.entry_bank    <= req.bank;
    in_ch.entry_program <= req.prog;
    in_ch.query_bank    <= req.qbank;
    in_ch.query_program <= req.qprog;
    in_ch.channel       <= req.chan;
    do @(posedge clk_i); while (!in_ch.ready);
    if (req.op == mptl_pkg::OP_WRITE) begin
      table_shadow[req.slot] = {req.bank, req.prog};
      slot_loaded[req.slot] = 1'b1;
    end else begin
      expected_lookups.push_back(predict_lookup(req.qbank, req.qprog, req.chan));
    end
    items_sent++;
  endtask

  task automatic send_write(input logic [mptl_pkg::SLOT_W-1:0] slot,
                            input logic [mptl_pkg::BANK_W-1:0] bank,
                            input logic [mptl_pkg::PROG_W-1:0] prog);
    midi_req_t req;
    req.op    = mptl_pkg::OP_WRITE;
    req.slot  = slot;
    req.bank  = bank;
    req.prog  = prog;
    req.qbank = mptl_pkg::QBANK_W'($urandom);
    req.qprog = mptl_pkg::PROG_W'($urandom);
    req.chan  = mptl_pkg::CHAN_W'($urandom);
    send_item(req);
  endtask

  task automatic send_query(input logic [mptl_pkg::QBANK_W-1:0] qbank,
                            input logic [mptl_pkg::PROG_W-1:0]  qprog,
                            input logic [mptl_pkg::CHAN_W-1:0]  chan);
    midi_req_t req;
    req.op    = mptl_pkg::OP_QUERY;
    req.slot  = mptl_pkg::SLOT_W'($urandom);
    req.bank  = mptl_pkg::BANK_W'($urandom);
    req.prog  = mptl_pkg::PROG_W'($urandom);
    req.qbank = qbank;
    req.qprog = qprog;
    req.chan  = chan;
    send_item(req);
  endtask

  // four in ten aimed at stored entries so that exact and fallback hits are common
  task automatic send_random_query();
    int                          n;
    int                          e;
    logic [mptl_pkg::BANK_W-1:0] b;
    logic [mptl_pkg::CHAN_W-1:0] ch;
    n = active_entries();
    ch = mptl_pkg::CHAN_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (n > 0) begin
          e = $urandom_range(n - 1, 0);
          b = table_shadow[e][mptl_pkg::ENTRY_W-1:mptl_pkg::PROG_W];
          if (b == mptl_pkg::DRUM_BANK) begin
            send_query(mptl_pkg::QBANK_W'($urandom), table_shadow[e][mptl_pkg::PROG_W-1:0],
                       mptl_pkg::DRUM_CHANNEL);
          end else begin
            if (ch == mptl_pkg::DRUM_CHANNEL) ch = '0;
            send_query(b[mptl_pkg::QBANK_W-1:0], table_shadow[e][mptl_pkg::PROG_W-1:0], ch);
          end
        end else begin
          send_query(mptl_pkg::QBANK_W'($urandom), mptl_pkg::PROG_W'($urandom), ch);
        end
      end
      4, 5: send_query(($urandom_range(0, 1) == 0) ? mptl_pkg::XG_DRUM_BANK_A
                                                  : mptl_pkg::XG_DRUM_BANK_B,
                       pick_prog(), ch);
      6: send_query(mptl_pkg::QBANK_W'($urandom), pick_prog(), mptl_pkg::DRUM_CHANNEL);
      default: send_query(mptl_pkg::QBANK_W'($urandom), pick_prog(), ch);
    endcase
  endtask

  task automatic send_random_write();
    int hi;
    hi = active_entries() + 7;
    if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
    if ($urandom_range(0, 1) == 0) begin
      send_write(mptl_pkg::SLOT_W'($urandom_range(0, hi)), pick_bank(), pick_prog());
    end else begin
      send_write(mptl_pkg::SLOT_W'($urandom), pick_bank(), pick_prog());
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input mptl_pkg::cfg_e idx,
                                input logic [mptl_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      mptl_pkg::CFG_MIDI_MODE:    mode_shadow = data[mptl_pkg::MODE_W-1:0];
      mptl_pkg::CFG_PRESET_COUNT: count_shadow = data[mptl_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // every not yet loaded entry below the new count and the table depth gets written before the count is set
  task automatic start_phase(input logic [mptl_pkg::MODE_W-1:0] mode, input int count);
    int i;
    for (i = 0; i < TABLE_DEPTH && i < count; i++) begin
      if (!slot_loaded[i]) send_write(mptl_pkg::SLOT_W'(i), pick_bank(), pick_prog());
    end
    drain_results();
    write_register(mptl_pkg::CFG_MIDI_MODE, mptl_pkg::CFG_DATA_W'(mode));
    write_register(mptl_pkg::CFG_PRESET_COUNT, mptl_pkg::CFG_DATA_W'(count));
  endtask

  task automatic test_empty_table();
    send_query('0, '0, '0);
    send_query('1, '1, '1);
    send_query(mptl_pkg::QBANK_W'(5), mptl_pkg::PROG_W'(5), mptl_pkg::DRUM_CHANNEL);
  endtask

  task automatic test_match_rules();
    send_write(mptl_pkg::SLOT_W'(0), mptl_pkg::BANK_W'(0), mptl_pkg::PROG_W'(5));
    send_write(mptl_pkg::SLOT_W'(1), mptl_pkg::DRUM_BANK, mptl_pkg::PROG_W'(35));
    send_write(mptl_pkg::SLOT_W'(2), mptl_pkg::BANK_W'(127), mptl_pkg::PROG_W'(0));
    send_write(mptl_pkg::SLOT_W'(3), '1, '1);
    send_write(mptl_pkg::SLOT_W'(4), mptl_pkg::BANK_W'(0), '1);
    send_write(mptl_pkg::SLOT_W'(5), mptl_pkg::BANK_W'(1), mptl_pkg::PROG_W'(10));
    send_write(mptl_pkg::SLOT_W'(6), mptl_pkg::BANK_W'(126), mptl_pkg::PROG_W'(20));
    send_write('1, mptl_pkg::DRUM_BANK, '1);
    start_phase(mptl_pkg::MODE_GM, 7);
    send_query(mptl_pkg::QBANK_W'(1), mptl_pkg::PROG_W'(10), '0);
    send_query(mptl_pkg::QBANK_W'(7), mptl_pkg::PROG_W'(5), '1);
    send_query(mptl_pkg::QBANK_W'(7), mptl_pkg::PROG_W'(99), mptl_pkg::CHAN_W'(3));
    send_query('0, '1, '0);
    send_query(mptl_pkg::XG_DRUM_BANK_B, '0, mptl_pkg::CHAN_W'(1));
    send_query(mptl_pkg::QBANK_W'(5), mptl_pkg::PROG_W'(35), mptl_pkg::DRUM_CHANNEL);
    send_query(mptl_pkg::QBANK_W'(5), mptl_pkg::PROG_W'(77), mptl_pkg::DRUM_CHANNEL);
    send_query(mptl_pkg::XG_DRUM_BANK_A, mptl_pkg::PROG_W'(20), mptl_pkg::CHAN_W'(2));
    start_phase(mptl_pkg::MODE_XG, 7);
    send_query(mptl_pkg::XG_DRUM_BANK_B, mptl_pkg::PROG_W'(35), '0);
    send_query(mptl_pkg::XG_DRUM_BANK_A, '0, mptl_pkg::CHAN_W'(4));
    send_query(mptl_pkg::XG_DRUM_BANK_B, '0, mptl_pkg::DRUM_CHANNEL);
    start_phase(mptl_pkg::MODE_RSVD, 7);
    send_query(mptl_pkg::XG_DRUM_BANK_B, '0, '0);
    start_phase(mptl_pkg::MODE_GS, 1);
    send_query(mptl_pkg::QBANK_W'(5), mptl_pkg::PROG_W'(35), mptl_pkg::DRUM_CHANNEL);
  endtask

  task automatic test_output_stall();
    start_phase(mptl_pkg::MODE_XG, 12);
    send_gap_max = 0;
    rx_hold_req = 1'b1;
    repeat (16) begin
      if ($urandom_range(0, 3) == 0) send_random_write();
      else send_random_query();
    end
    drain_results();
    send_gap_max = 7;
  endtask

  task automatic test_full_table();
    start_phase(mptl_pkg::MODE_GS, TABLE_DEPTH);
    send_write('1, mptl_pkg::BANK_W'(77), mptl_pkg::PROG_W'(99));
    send_query(mptl_pkg::QBANK_W'(77), mptl_pkg::PROG_W'(99), '0);
    repeat (6) send_random_query();
    start_phase(mptl_pkg::MODE_XG, 511);
    repeat (6) send_random_query();
  endtask

  task automatic test_random_traffic();
    int cnt;
    int len;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0:       cnt = 0;
        1:       cnt = TABLE_DEPTH;
        2:       cnt = $urandom_range(TABLE_DEPTH + 1, 511);
        3:       cnt = 1;
        default: cnt = $urandom_range(2, 24);
      endcase
      start_phase(mptl_pkg::MODE_W'($urandom_range(0, 3)), cnt);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      len = $urandom_range(20, 60);
      repeat (len) begin
        if ($urandom_range(0, 9) < 7) send_random_query();
        else send_random_write();
      end
    end
    send_gap_max = 7;
    recv_gap_max = 7;
  endtask

  initial begin : result_checker
    int             rx_wait;
    mptl_pkg::res_t want;
    rx_wait = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d kind %0d",
                                    out_ch.found_index, out_ch.match_kind));
        end else begin
          want = expected_lookups.pop_front();
          if (out_ch.found_index !== want.found_index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      out_ch.found_index, want.found_index));
          if (out_ch.match_kind !== want.match_kind)
            report_mismatch($sformatf("match_kind %0d, expected %s",
                                      out_ch.match_kind, want.match_kind.name()));
        end
        rx_wait = $urandom_range(recv_gap_max, 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      // long output stall so the unit fills up and blocks its input
      if (rx_hold_req) begin
        rx_wait = RX_HOLD;
        rx_hold_req = 1'b0;
      end
      out_ch.ready <= (rx_wait == 0) && rst_ni;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.opcode        = mptl_pkg::OP_WRITE;
    in_ch.entry_slot    = '0;
    in_ch.entry_bank    = '0;
    in_ch.entry_program = '0;
    in_ch.query_bank    = '0;
    in_ch.query_program = '0;
    in_ch.channel       = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_match_rules();
    test_output_stall();
    test_full_table();
    test_random_traffic();
    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
